[hdl/dlsp_pkg.sv]
// shared types, constants and the sigmoid lookup contents for the dense layer core
package dlsp_pkg;

	// action codes
	localparam logic [2:0] ACT_WRITE_WEIGHT = 3'd0;
	localparam logic [2:0] ACT_WRITE_NEURON = 3'd1;
	localparam logic [2:0] ACT_RUN_UP       = 3'd2;
	localparam logic [2:0] ACT_RUN_DOWN     = 3'd3;
	localparam logic [2:0] ACT_READ_NEURON  = 3'd4;

	// field and register widths
	localparam int ACT_W   = 3;
	localparam int LAYER_W = 2;
	localparam int IDX_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int COUNT_W = 3;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_SIZES  = 4;
	localparam int LAYER_LIMIT = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_ZERO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_ONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TWO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_THREE  = 3'd4;

	// reset values of the configuration
	localparam logic [COUNT_W-1:0] LAYER_COUNT_RST = 3'd4;
	localparam logic [SIZE_W-1:0]  SIZE_RST        = 7'd64;

	// parameter defaults
	localparam int MAX_LAYERS_DEF  = 4;
	localparam int MAX_NEURONS_DEF = 64;

	// sigmoid table
	localparam int SIG_DEPTH = 1024;
	localparam int SIG_IDX_W = 10;
	typedef logic [VAL_W-1:0] sig_tab_t [SIG_DEPTH];

	// controller to datapath commands, neuron indexes as wide as a layer size
	typedef struct packed {
		logic               nrn_wr_en;
		logic               nrn_wr_sig;
		logic [LAYER_W-1:0] nrn_wr_layer;
		logic [SIZE_W-1:0]  nrn_wr_idx;
		logic               nrn_rd_en;
		logic [LAYER_W-1:0] nrn_rd_layer;
		logic [SIZE_W-1:0]  nrn_rd_idx;
		logic               wgt_wr_en;
		logic               wgt_rd_en;
		logic [LAYER_W-1:0] wgt_layer;
		logic [SIZE_W-1:0]  wgt_lo;
		logic [SIZE_W-1:0]  wgt_up;
		logic               mac_vld;
		logic               acc_clr;
		logic               sig_idx_en;
		logic               sig_rd_en;
	} dlsp_cmd_t;

	// restoring long division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// rounded logistic function in Q4.12 over [-8, 8) in steps of 1/64
	function automatic sig_tab_t build_sig_table();
		sig_tab_t     tab;
		logic [63:0]  term;
		logic [63:0]  plus;
		logic [63:0]  minus;
		logic [63:0]  r;
		logic [63:0]  q;
		logic [63:0]  d;
		logic [127:0] prod;
		term  = 64'd1 << 60;
		plus  = 64'd1 << 60;
		minus = '0;
		// exp(-1/64) in Q60 by its series
		for (int k = 1; k <= 20; k++) begin
			term = udiv64(term, 64'(64 * k));
			if ((k & 1) == 1) minus = minus + term;
			else plus = plus + term;
		end
		r = plus - minus;
		q = 64'd1 << 60;
		for (int j = 0; j <= 512; j++) begin
			d = ((64'd1 << 60) + q) >> 20;
			if (j < 512) tab[512 + j] = 16'(udiv64((64'd1 << 53) + d, d << 1));
			if (j >= 1) tab[512 - j] = 16'(udiv64((64'd8192 * (q >> 20)) + d, d << 1));
			prod = 128'(q) * 128'(r);
			q = prod[123:60];
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

[hdl/dlsp_datapath.sv]
// neuron and weight stores, multiply-accumulate pipeline and sigmoid lookup
module dlsp_datapath #(
	parameter int MAX_LAYERS  = dlsp_pkg::MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = dlsp_pkg::MAX_NEURONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dlsp_pkg::dlsp_cmd_t          cmd,
	input  logic [dlsp_pkg::VAL_W-1:0]   write_value,
	output logic [dlsp_pkg::VAL_W-1:0]   nrn_rdata
);
	import dlsp_pkg::*;

	localparam int NRN_DEPTH = MAX_LAYERS * MAX_NEURONS;
	localparam int WGT_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
	localparam int NAW = $clog2(NRN_DEPTH);
	localparam int WAW = $clog2(WGT_DEPTH);

	logic [VAL_W-1:0] nrn_mem [NRN_DEPTH];
	logic [VAL_W-1:0] wgt_mem [WGT_DEPTH];

	logic [31:0]      nrn_wa_full;
	logic [31:0]      nrn_ra_full;
	logic [31:0]      wgt_a_full;
	logic [NAW-1:0]   nrn_waddr;
	logic [NAW-1:0]   nrn_raddr;
	logic [WAW-1:0]   wgt_addr;
	logic [VAL_W-1:0] nrn_wdata;

	logic [VAL_W-1:0]     nrn_s1;
	logic [VAL_W-1:0]     wgt_s1;
	logic                 mac_vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                 mac_vld_s2;
	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W:0]       acc_sum;
	logic [ACC_W-1:0]     acc_next;
	logic [SIG_IDX_W-1:0] sig_idx_d;
	logic [SIG_IDX_W-1:0] sig_idx_q;
	logic [VAL_W-1:0]     sig_q;

	// address generation
	assign nrn_wa_full = 32'(cmd.nrn_wr_layer) * 32'(MAX_NEURONS) + 32'(cmd.nrn_wr_idx);
	assign nrn_ra_full = 32'(cmd.nrn_rd_layer) * 32'(MAX_NEURONS) + 32'(cmd.nrn_rd_idx);
	assign wgt_a_full  = (32'(cmd.wgt_layer) * 32'(MAX_NEURONS) + 32'(cmd.wgt_lo))
		* 32'(MAX_NEURONS) + 32'(cmd.wgt_up);
	assign nrn_waddr = nrn_wa_full[NAW-1:0];
	assign nrn_raddr = nrn_ra_full[NAW-1:0];
	assign wgt_addr  = wgt_a_full[WAW-1:0];
	assign nrn_wdata = cmd.nrn_wr_sig ? sig_q : write_value;

	// neuron store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.nrn_wr_en) nrn_mem[nrn_waddr] <= nrn_wdata;
		if (cmd.nrn_rd_en) nrn_s1 <= nrn_mem[nrn_raddr];
	end

	// weight store, single port
	always_ff @(posedge clk) begin
		if (cmd.wgt_wr_en) wgt_mem[wgt_addr] <= write_value;
		if (cmd.wgt_rd_en) wgt_s1 <= wgt_mem[wgt_addr];
	end

	assign nrn_rdata = nrn_s1;

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(nrn_s1) * $signed(wgt_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_s1 <= 1'b0;
			mac_vld_s2 <= 1'b0;
		end else begin
			mac_vld_s1 <= cmd.mac_vld;
			mac_vld_s2 <= mac_vld_s1;
		end
	end

	// saturating accumulate
	always_comb begin
		acc_sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) acc_q <= '0;
		else if (mac_vld_s2) acc_q <= acc_next;
	end

	// clamp to [-8, 8) and take the table index
	always_comb begin
		if (acc_q[ACC_W-1] && !(&acc_q[ACC_W-1:27])) sig_idx_d = '0;
		else if (!acc_q[ACC_W-1] && (|acc_q[ACC_W-1:27])) sig_idx_d = '1;
		else sig_idx_d = {~acc_q[27], acc_q[26:18]};
	end

	// table lookup, registered
	always_ff @(posedge clk) begin
		if (cmd.sig_idx_en) sig_idx_q <= sig_idx_d;
		if (cmd.sig_rd_en) sig_q <= SIG_TABLE[sig_idx_q];
	end

endmodule

[hdl/dlsp_ctrl.sv]
// controller: item decode, layer and neuron sequencing, result register
module dlsp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dlsp_pkg::ACT_W-1:0]     action,
	input  logic [dlsp_pkg::LAYER_W-1:0]   layer_index,
	input  logic [dlsp_pkg::IDX_W-1:0]     lower_index,
	input  logic [dlsp_pkg::IDX_W-1:0]     upper_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dlsp_pkg::VAL_W-1:0]     read_value,
	output logic                           status,
	input  logic [dlsp_pkg::COUNT_W-1:0]   layers_used,
	input  logic [dlsp_pkg::NUM_SIZES-1:0][dlsp_pkg::SIZE_W-1:0] size_used,
	input  logic [dlsp_pkg::VAL_W-1:0]     nrn_rdata,
	output dlsp_pkg::dlsp_cmd_t            cmd
);
	import dlsp_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_MAC    = 3'd2;
	localparam logic [2:0] ST_DRAIN1 = 3'd3;
	localparam logic [2:0] ST_DRAIN2 = 3'd4;
	localparam logic [2:0] ST_SIGX   = 3'd5;
	localparam logic [2:0] ST_SIGR   = 3'd6;
	localparam logic [2:0] ST_WRITE  = 3'd7;

	logic [2:0]         state_q, state_d;
	logic               dir_up_q, dir_up_d;
	logic [LAYER_W-1:0] tgt_q, tgt_d;
	logic [LAYER_W-1:0] l_q, l_d;
	logic [SIZE_W-1:0]  n_q, n_d;
	logic [SIZE_W-1:0]  m_q, m_d;

	logic               res_vld_q;
	logic [VAL_W-1:0]   res_rd_q;
	logic               res_st_q;
	logic               res_load;
	logic [VAL_W-1:0]   res_rd_d;
	logic               res_st_d;

	logic               accept;
	logic [LAYER_W-1:0] up_layer;
	logic               layer_ok;
	logic               wlayer_ok;
	logic               lo_ok;
	logic               up_ok;
	logic [LAYER_W-1:0] src_layer;
	logic [LAYER_W-1:0] dst_layer;
	logic [SIZE_W-1:0]  in_cnt;
	logic [SIZE_W-1:0]  out_cnt;
	logic               m_last;
	logic               n_last;
	logic               l_last;

	assign in_ready   = (state_q == ST_IDLE) && (!res_vld_q || out_ready);
	assign accept     = in_valid && in_ready;
	assign out_valid  = res_vld_q;
	assign read_value = res_rd_q;
	assign status     = res_st_q;

	// range checks on the incoming transaction
	assign up_layer  = layer_index + 2'd1;
	assign layer_ok  = {1'b0, layer_index} < layers_used;
	assign wlayer_ok = ({1'b0, layer_index} + 3'd1) < layers_used;
	assign lo_ok     = {1'b0, lower_index} < size_used[layer_index];
	assign up_ok     = {1'b0, upper_index} < size_used[up_layer];

	// layer roles of the pass in progress
	assign src_layer = dir_up_q ? l_q - 2'd1 : l_q;
	assign dst_layer = dir_up_q ? l_q : l_q - 2'd1;
	assign in_cnt    = size_used[src_layer];
	assign out_cnt   = size_used[dst_layer];
	assign m_last    = m_q == in_cnt - 7'd1;
	assign n_last    = n_q == out_cnt - 7'd1;
	assign l_last    = dir_up_q ? (l_q == tgt_q) : (l_q == 2'd1);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		dir_up_d = dir_up_q;
		tgt_d    = tgt_q;
		l_d      = l_q;
		n_d      = n_q;
		m_d      = m_q;
		res_load = 1'b0;
		res_rd_d = '0;
		res_st_d = 1'b0;
		cmd      = '0;

		unique case (state_q)
			ST_IDLE: begin
				cmd.nrn_wr_layer = layer_index;
				cmd.nrn_wr_idx   = SIZE_W'(lower_index);
				cmd.nrn_rd_layer = layer_index;
				cmd.nrn_rd_idx   = SIZE_W'(lower_index);
				cmd.wgt_layer    = layer_index;
				cmd.wgt_lo       = SIZE_W'(lower_index);
				cmd.wgt_up       = SIZE_W'(upper_index);
				if (accept) begin
					case (action) inside
						ACT_WRITE_WEIGHT: begin
							cmd.wgt_wr_en = wlayer_ok && lo_ok && up_ok;
							res_load = 1'b1;
							res_st_d = !(wlayer_ok && lo_ok && up_ok);
						end
						ACT_WRITE_NEURON: begin
							cmd.nrn_wr_en = layer_ok && lo_ok;
							res_load = 1'b1;
							res_st_d = !(layer_ok && lo_ok);
						end
						ACT_READ_NEURON: begin
							if (layer_ok && lo_ok) begin
								cmd.nrn_rd_en = 1'b1;
								state_d = ST_READ;
							end else begin
								res_load = 1'b1;
								res_st_d = 1'b1;
							end
						end
						ACT_RUN_UP, ACT_RUN_DOWN: begin
							if (!layer_ok) begin
								res_load = 1'b1;
								res_st_d = 1'b1;
							end else if (layer_index == 2'd0) begin
								res_load = 1'b1;
							end else begin
								dir_up_d = (action == ACT_RUN_UP);
								tgt_d    = layer_index;
								l_d      = (action == ACT_RUN_UP) ? 2'd1 : layer_index;
								n_d      = '0;
								m_d      = '0;
								state_d  = ST_MAC;
							end
						end
						default: begin
							res_load = 1'b1;
							res_st_d = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_rd_d = nrn_rdata;
				state_d  = ST_IDLE;
			end
			ST_MAC: begin
				// one product per cycle into the accumulator
				cmd.nrn_rd_en    = 1'b1;
				cmd.nrn_rd_layer = src_layer;
				cmd.nrn_rd_idx   = m_q;
				cmd.wgt_rd_en    = 1'b1;
				cmd.wgt_layer    = l_q - 2'd1;
				cmd.wgt_lo       = dir_up_q ? m_q : n_q;
				cmd.wgt_up       = dir_up_q ? n_q : m_q;
				cmd.mac_vld      = 1'b1;
				cmd.acc_clr      = (m_q == '0);
				if (m_last) begin
					m_d     = '0;
					state_d = ST_DRAIN1;
				end else begin
					m_d = m_q + 7'd1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_SIGX;
			ST_SIGX: begin
				cmd.sig_idx_en = 1'b1;
				state_d = ST_SIGR;
			end
			ST_SIGR: begin
				cmd.sig_rd_en = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.nrn_wr_en    = 1'b1;
				cmd.nrn_wr_sig   = 1'b1;
				cmd.nrn_wr_layer = dst_layer;
				cmd.nrn_wr_idx   = n_q;
				if (n_last) begin
					n_d = '0;
					if (l_last) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						l_d     = dir_up_q ? l_q + 2'd1 : l_q - 2'd1;
						state_d = ST_MAC;
					end
				end else begin
					n_d     = n_q + 7'd1;
					state_d = ST_MAC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) res_vld_q <= 1'b1;
			else if (out_ready) res_vld_q <= 1'b0;
		end
	end

	// pass counters and result payload
	always_ff @(posedge clk) begin
		dir_up_q <= dir_up_d;
		tgt_q    <= tgt_d;
		l_q      <= l_d;
		n_q      <= n_d;
		m_q      <= m_d;
		if (res_load) begin
			res_rd_q <= res_rd_d;
			res_st_q <= res_st_d;
		end
	end

endmodule

[hdl/dense_layer_sigmoid_propagation_core.sv]
// top level of the dense layer sigmoid propagation core
// Holds neuron values and weight matrices for up to four fully connected layers in signed
// Q4.12 and runs sigmoid forward passes upward to a target layer or downward from it to
// layer zero. Weight and neuron writes finish in the cycle they are taken, a neuron read
// returns through the registered store read and the result register, and a run computes
// each output neuron of every layer it covers in turn: the single multiply-accumulate
// unit and the single port of the weight store take one weight per cycle, followed by
// pipeline drain, sigmoid table lookup and write-back. A new transaction is taken once
// the core is idle and its result register is empty or being emptied. Stores come up
// unwritten and must be loaded before they are read or used by a run.
module dense_layer_sigmoid_propagation_core #(
	parameter int MAX_LAYERS  = dlsp_pkg::MAX_LAYERS_DEF,
	parameter int MAX_NEURONS = dlsp_pkg::MAX_NEURONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dlsp_pkg::ACT_W-1:0]       action,
	input  logic [dlsp_pkg::LAYER_W-1:0]     layer_index,
	input  logic [dlsp_pkg::IDX_W-1:0]       lower_index,
	input  logic [dlsp_pkg::IDX_W-1:0]       upper_index,
	input  logic signed [dlsp_pkg::VAL_W-1:0] write_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [dlsp_pkg::VAL_W-1:0] read_value,
	output logic                             status,
	input  logic                             cfg_we,
	input  logic [dlsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlsp_pkg::SIZE_W-1:0]      cfg_data
);
	import dlsp_pkg::*;

	localparam int LIM_LAYERS = (MAX_LAYERS < LAYER_LIMIT) ? MAX_LAYERS : LAYER_LIMIT;
	localparam logic [COUNT_W-1:0] LIM_CODE = COUNT_W'(LIM_LAYERS);
	localparam logic [10:0] MAXN_CODE = 11'(MAX_NEURONS);

	logic [COUNT_W-1:0]                 layer_count_q;
	logic [NUM_SIZES-1:0][SIZE_W-1:0]   size_q;
	logic [COUNT_W-1:0]                 layers_used;
	logic [NUM_SIZES-1:0][SIZE_W-1:0]   size_used;
	dlsp_cmd_t                          cmd;
	logic [VAL_W-1:0]                   nrn_rdata;
	logic [VAL_W-1:0]                   read_value_u;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= LAYER_COUNT_RST;
			size_q        <= {NUM_SIZES{SIZE_RST}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LAYER_COUNT: layer_count_q <= cfg_data[COUNT_W-1:0];
				CFG_SIZE_ZERO:   size_q[0] <= cfg_data;
				CFG_SIZE_ONE:    size_q[1] <= cfg_data;
				CFG_SIZE_TWO:    size_q[2] <= cfg_data;
				CFG_SIZE_THREE:  size_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp configuration to usable values
	always_comb begin
		if (layer_count_q < 3'd2) layers_used = 3'd2;
		else if (layer_count_q > LIM_CODE) layers_used = LIM_CODE;
		else layers_used = layer_count_q;
		for (int i = 0; i < NUM_SIZES; i++) begin
			if (size_q[i] == '0) size_used[i] = 7'd1;
			else if ({4'd0, size_q[i]} > MAXN_CODE) size_used[i] = MAXN_CODE[SIZE_W-1:0];
			else size_used[i] = size_q[i];
		end
	end

	dlsp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.layer_index (layer_index),
		.lower_index (lower_index),
		.upper_index (upper_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value_u),
		.status      (status),
		.layers_used (layers_used),
		.size_used   (size_used),
		.nrn_rdata   (nrn_rdata),
		.cmd         (cmd)
	);

	dlsp_datapath #(
		.MAX_LAYERS  (MAX_LAYERS),
		.MAX_NEURONS (MAX_NEURONS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.write_value (write_value),
		.nrn_rdata   (nrn_rdata)
	);

	assign read_value = read_value_u;

`ifndef NO_ASSERTIONS
	// a rejected transaction never carries a read value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_value == '0)
		else $error("rejected transaction with nonzero read value");

	// new work is taken only when the pending result leaves
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready)
		else $error("input taken while result register stays full");

	// the neuron and weight stores are never written in the same cycle
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.nrn_wr_en && cmd.wgt_wr_en))
		else $error("neuron and weight written together");
`endif

endmodule

[dv/dense_layer_sigmoid_propagation_core_test.sv]
// self-checking testbench for the dense layer sigmoid propagation core
`timescale 1ns / 1ps

module dense_layer_sigmoid_propagation_core_test;
	import dlsp_pkg::*;

	localparam int NL = 4;
	localparam int NN = 64;
	localparam int NFILL = 8;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	localparam longint SIG_HALF = 64'sd134217728;

	// one row of directed stimulus, with an optional typed-in result
	typedef struct packed {
		logic [ACT_W-1:0]   act;
		logic [LAYER_W-1:0] li;
		logic [IDX_W-1:0]   lo;
		logic [IDX_W-1:0]   up;
		logic [VAL_W-1:0]   wv;
		logic               typed;
		logic [VAL_W-1:0]   rd;
		logic               st;
	} dir_row_t;

	typedef struct packed {
		logic               typed;
		logic [VAL_W-1:0]   rd;
		logic               st;
	} result_t;

	localparam int NDIR = 22;
	// rows from here on run with small layers
	localparam int DIR_CFG_ROW = 14;
	localparam dir_row_t DIR_ROWS [NDIR] = '{
		'{ACT_WRITE_NEURON, 2'd0, 6'd63, 6'd0,  16'h7fff, 1'b1, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd0, 6'd63, 6'd0,  16'h0000, 1'b1, 16'h7fff, 1'b0},
		'{ACT_WRITE_NEURON, 2'd0, 6'd0,  6'd0,  16'h8000, 1'b1, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd0, 6'd0,  6'd0,  16'h0000, 1'b1, 16'h8000, 1'b0},
		'{ACT_WRITE_NEURON, 2'd3, 6'd63, 6'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd3, 6'd63, 6'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
		'{ACT_WRITE_WEIGHT, 2'd2, 6'd63, 6'd63, 16'h7fff, 1'b1, 16'h0000, 1'b0},
		'{ACT_WRITE_WEIGHT, 2'd0, 6'd0,  6'd0,  16'h8000, 1'b1, 16'h0000, 1'b0},
		'{ACT_WRITE_WEIGHT, 2'd3, 6'd0,  6'd0,  16'h1234, 1'b1, 16'h0000, 1'b1},
		'{3'd5,             2'd0, 6'd0,  6'd0,  16'h0000, 1'b1, 16'h0000, 1'b1},
		'{3'd6,             2'd1, 6'd1,  6'd1,  16'hffff, 1'b1, 16'h0000, 1'b1},
		'{3'd7,             2'd3, 6'd63, 6'd63, 16'h5555, 1'b1, 16'h0000, 1'b1},
		'{ACT_RUN_UP,       2'd0, 6'd0,  6'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
		'{ACT_RUN_DOWN,     2'd0, 6'd0,  6'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
		'{ACT_RUN_UP,       2'd3, 6'd0,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd3, 6'd5,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd2, 6'd7,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_RUN_DOWN,     2'd3, 6'd0,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd0, 6'd17, 6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_RUN_UP,       2'd1, 6'd0,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_READ_NEURON,  2'd1, 6'd7,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
		'{ACT_RUN_DOWN,     2'd2, 6'd0,  6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [ACT_W-1:0]          action;
	logic [LAYER_W-1:0]        layer_index;
	logic [IDX_W-1:0]          lower_index;
	logic [IDX_W-1:0]          upper_index;
	logic signed [VAL_W-1:0]   write_value;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VAL_W-1:0]   read_value;
	logic                      status;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [SIZE_W-1:0]         cfg_data;

	// predictor state
	logic [VAL_W-1:0]   nrn_mdl [NL*NN];
	logic [VAL_W-1:0]   wgt_mdl [(NL-1)*NN*NN];
	logic [VAL_W-1:0]   logistic [1024];
	logic [COUNT_W-1:0] count_reg;
	logic [SIZE_W-1:0]  size_reg [4];

	// entries written so far, as seen by the stimulus
	bit                 nrn_set [NL*NN];
	bit                 wgt_set [(NL-1)*NN*NN];

	result_t result_q [$];
	result_t typed_q [$];
	int      fails;
	int      rdy_mode;

	dense_layer_sigmoid_propagation_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .layer_index(layer_index),
		.lower_index(lower_index), .upper_index(upper_index),
		.write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// rounded logistic over [-8, 8) in steps of 1/64, from a series for exp(-1/64)
	task automatic build_logistic();
		longint unsigned term, plus, minus, r, q, d;
		logic [127:0]    p;
		term = 64'd1 << 60;
		plus = 64'd1 << 60;
		minus = 0;
		for (int k = 1; k <= 20; k++) begin
			term = term / (64 * k);
			if (k % 2) minus += term;
			else plus += term;
		end
		r = plus - minus;
		q = 64'd1 << 60;
		for (int j = 0; j <= 512; j++) begin
			d = ((64'd1 << 60) + q) >> 20;
			if (j < 512) logistic[512 + j] = 16'(((64'd4096 << 41) + d) / (2 * d));
			if (j >= 1) logistic[512 - j] = 16'((64'd8192 * (q >> 20) + d) / (2 * d));
			p = {64'd0, q} * {64'd0, r};
			q = p[123:60];
		end
	endtask

	function automatic int layers_in_use();
		int c;
		c = count_reg;
		if (c < 2) c = 2;
		if (c > 4) c = 4;
		return c;
	endfunction

	function automatic int neurons_in(int l);
		int s;
		s = size_reg[l];
		if (s < 1) s = 1;
		if (s > NN) s = NN;
		return s;
	endfunction

	function automatic int wgt_addr(int l, int lo, int up);
		return (l * NN + lo) * NN + up;
	endfunction

	// true when the transaction reads only entries that were written before
	function automatic bit covered(logic [ACT_W-1:0] a, int li, int lo);
		int used;
		int src;
		used = layers_in_use();
		if (a == ACT_READ_NEURON)
			return !(li < used && lo < neurons_in(li)) || nrn_set[li*NN + lo];
		if (a != ACT_RUN_UP && a != ACT_RUN_DOWN) return 1'b1;
		if (li >= used || li == 0) return 1'b1;
		src = (a == ACT_RUN_UP) ? 0 : li;
		for (int n = 0; n < neurons_in(src); n++)
			if (!nrn_set[src*NN + n]) return 1'b0;
		for (int l = 1; l <= li; l++)
			for (int x = 0; x < neurons_in(l - 1); x++)
				for (int y = 0; y < neurons_in(l); y++)
					if (!wgt_set[wgt_addr(l - 1, x, y)]) return 1'b0;
		return 1'b1;
	endfunction

	// note the entries a transaction writes
	function automatic void mark_written(logic [ACT_W-1:0] a, int li, int lo, int up);
		int used;
		used = layers_in_use();
		case (a)
			ACT_WRITE_WEIGHT:
				if (li + 1 < used && lo < neurons_in(li) && up < neurons_in(li + 1))
					wgt_set[wgt_addr(li, lo, up)] = 1'b1;
			ACT_WRITE_NEURON:
				if (li < used && lo < neurons_in(li)) nrn_set[li*NN + lo] = 1'b1;
			ACT_RUN_UP:
				if (li < used)
					for (int l = 1; l <= li; l++)
						for (int n = 0; n < neurons_in(l); n++) nrn_set[l*NN + n] = 1'b1;
			ACT_RUN_DOWN:
				if (li < used)
					for (int l = li; l > 0; l--)
						for (int n = 0; n < neurons_in(l - 1); n++)
							nrn_set[(l-1)*NN + n] = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] squash(longint acc);
		longint a;
		a = acc;
		if (a < -SIG_HALF) a = -SIG_HALF;
		if (a > SIG_HALF - 1) a = SIG_HALF - 1;
		return logistic[((a + SIG_HALF) >>> 18) & 1023];
	endfunction

	// one neuron of a pass: dot product of src layer with a weight row or column
	function automatic logic [VAL_W-1:0] neuron_value(int src, int wl, int n, bit transposed);
		longint acc;
		int      wa;
		acc = 0;
		for (int m = 0; m < neurons_in(src); m++) begin
			wa = transposed ? wgt_addr(wl, n, m) : wgt_addr(wl, m, n);
			acc += longint'($signed(nrn_mdl[src*NN + m])) * longint'($signed(wgt_mdl[wa]));
			if (acc > ACC_HI) acc = ACC_HI;
			if (acc < ACC_LO) acc = ACC_LO;
		end
		return squash(acc);
	endfunction

	// predict the result of one transaction and update the stores
	task automatic predict_transaction(input logic [ACT_W-1:0] a, input int li, input int lo,
			input int up, input logic [VAL_W-1:0] wv, output result_t res);
		int used;
		used = layers_in_use();
		res = '0;
		case (a) inside
			ACT_WRITE_WEIGHT: begin
				if (li + 1 < used && lo < neurons_in(li) && up < neurons_in(li + 1))
					wgt_mdl[wgt_addr(li, lo, up)] = wv;
				else res.st = 1'b1;
			end
			ACT_WRITE_NEURON, ACT_READ_NEURON: begin
				if (li < used && lo < neurons_in(li)) begin
					if (a == ACT_WRITE_NEURON) nrn_mdl[li*NN + lo] = wv;
					else res.rd = nrn_mdl[li*NN + lo];
				end else res.st = 1'b1;
			end
			ACT_RUN_UP: begin
				if (li >= used) res.st = 1'b1;
				else for (int l = 1; l <= li; l++)
					for (int n = 0; n < neurons_in(l); n++)
						nrn_mdl[l*NN + n] = neuron_value(l - 1, l - 1, n, 1'b0);
			end
			ACT_RUN_DOWN: begin
				if (li >= used) res.st = 1'b1;
				else for (int l = li; l > 0; l--)
					for (int n = 0; n < neurons_in(l - 1); n++)
						nrn_mdl[(l-1)*NN + n] = neuron_value(l, l - 1, n, 1'b1);
			end
			default: res.st = 1'b1;
		endcase
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver stall pattern, changing character at random times
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rdy_mode <= 0;
		end else begin
			if ($urandom_range(0, 299) == 0) rdy_mode <= $urandom_range(0, 3);
			case (rdy_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// predict on each accepted input transaction, check each accepted result
	always @(posedge clk) begin
		result_t res;
		result_t tr;
		result_t got;
		if (arst_n && in_valid && in_ready) begin
			predict_transaction(action, layer_index, lower_index, upper_index, write_value, res);
			tr = typed_q.pop_front();
			if (tr.typed) res = tr;
			result_q.push_back(res);
		end
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fails++;
			end else begin
				got = result_q.pop_front();
				if (read_value !== got.rd) begin
					$error("read_value expected %h actual %h", got.rd, read_value);
					fails++;
				end
				if (status !== got.st) begin
					$error("status expected %0d actual %0d", got.st, status);
					fails++;
				end
			end
		end
	end

	task automatic send_transaction(input logic [ACT_W-1:0] a, input logic [LAYER_W-1:0] li,
			input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] up,
			input logic [VAL_W-1:0] wv, input result_t tr);
		mark_written(a, li, lo, up);
		typed_q.push_back(tr);
		in_valid <= 1'b1;
		action <= a;
		layer_index <= li;
		lower_index <= lo;
		upper_index <= up;
		write_value <= wv;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_cycles(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every expected result has arrived
	task automatic drain();
		pause_cycles(1);
		while (result_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_registers(input logic [SIZE_W-1:0] cnt, input logic [SIZE_W-1:0] s0,
			input logic [SIZE_W-1:0] s1, input logic [SIZE_W-1:0] s2,
			input logic [SIZE_W-1:0] s3);
		logic [SIZE_W-1:0] vals [5];
		logic [CFG_IDX_W-1:0] idx [5];
		vals = '{cnt, s0, s1, s2, s3};
		idx = '{CFG_LAYER_COUNT, CFG_SIZE_ZERO, CFG_SIZE_ONE, CFG_SIZE_TWO, CFG_SIZE_THREE};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		count_reg = cnt[COUNT_W-1:0];
		for (int i = 0; i < 4; i++) size_reg[i] = vals[i + 1];
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		if ($urandom_range(0, 2) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2047)) - 1024);
	endfunction

	function automatic logic [IDX_W-1:0] rand_index(int lim);
		if ($urandom_range(0, 9) < 8) return IDX_W'($urandom_range(0, lim - 1));
		return IDX_W'($urandom_range(0, 63));
	endfunction

	// stimulus
	initial begin
		int burst;
		int run_pct;
		int pick;
		int li;
		logic [ACT_W-1:0] a;
		logic [SIZE_W-1:0] sz [4];
		logic [SIZE_W-1:0] cnt;
		logic [IDX_W-1:0] lo_sel;
		logic [IDX_W-1:0] up_sel;
		result_t none;
		none = '0;
		fails = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		action <= ACT_WRITE_WEIGHT;
		layer_index <= '0;
		lower_index <= '0;
		upper_index <= '0;
		write_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LAYER_COUNT;
		cfg_data <= '0;
		build_logistic();
		count_reg = LAYER_COUNT_RST;
		for (int i = 0; i < 4; i++) size_reg[i] = SIZE_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the low corner of every weight matrix and layer
		for (int l = 0; l < NL - 1; l++)
			for (int lo = 0; lo < NFILL; lo++)
				for (int up = 0; up < NFILL; up++)
					send_transaction(ACT_WRITE_WEIGHT, LAYER_W'(l), IDX_W'(lo), IDX_W'(up),
						rand_value(), none);
		for (int l = 0; l < NL; l++)
			for (int n = 0; n < NFILL; n++)
				send_transaction(ACT_WRITE_NEURON, LAYER_W'(l), IDX_W'(n), '0,
					rand_value(), none);

		// directed rows, extremes at the reset configuration, runs on small layers
		foreach (DIR_ROWS[i]) begin
			if (i == DIR_CFG_ROW) begin
				drain();
				write_registers(7'd4, 7'(NFILL), 7'(NFILL), 7'(NFILL), 7'(NFILL));
			end
			send_transaction(DIR_ROWS[i].act, DIR_ROWS[i].li, DIR_ROWS[i].lo, DIR_ROWS[i].up,
				DIR_ROWS[i].wv, '{DIR_ROWS[i].typed, DIR_ROWS[i].rd, DIR_ROWS[i].st});
			pause_cycles($urandom_range(0, 2));
		end
		drain();

		// random phases, each under its own configuration
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin cnt = 7'd2; sz = '{7'd1, 7'd1, 7'd1, 7'd1}; end
				1: begin cnt = 7'd4; sz = '{7'd64, 7'd64, 7'd64, 7'd64}; end
				2: begin cnt = 7'd0; sz = '{7'd0, 7'd127, 7'd0, 7'd65}; end
				3: begin cnt = 7'd7; sz = '{7'd127, 7'd2, 7'd100, 7'd3}; end
				4: begin cnt = 7'd3; sz = '{7'd64, 7'd1, 7'd64, 7'd5}; end
				default: begin
					cnt = 7'($urandom_range(2, 4));
					foreach (sz[k]) sz[k] = 7'($urandom_range(1, 12));
				end
			endcase
			write_registers(cnt, sz[0], sz[1], sz[2], sz[3]);
			run_pct = (neurons_in(0) + neurons_in(1) + neurons_in(2) + neurons_in(3) > 64)
				? 2 : 15;
			for (int it = 0; it < 95; ) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst && it < 95; b++, it++) begin
					pick = $urandom_range(0, 99);
					li = $urandom_range(0, 3);
					if (pick < run_pct) a = $urandom_range(0, 1) ? ACT_RUN_UP : ACT_RUN_DOWN;
					else if (pick < run_pct + 5) a = 3'($urandom_range(5, 7));
					else case ($urandom_range(0, 2))
						0: a = ACT_WRITE_WEIGHT;
						1: a = ACT_WRITE_NEURON;
						default: a = ACT_READ_NEURON;
					endcase
					if (a == ACT_WRITE_WEIGHT && $urandom_range(0, 4) != 0)
						li = $urandom_range(0, layers_in_use() - 2);
					lo_sel = rand_index(neurons_in(li));
					up_sel = rand_index(neurons_in((li + 1) % 4));
					// never read an entry that was not written
					if (!covered(a, li, lo_sel)) a = ACT_WRITE_NEURON;
					send_transaction(a, LAYER_W'(li), lo_sel, up_sel, rand_value(), none);
				end
				if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 6));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fails == 0 && result_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[files.f]
hdl/dlsp_pkg.sv
hdl/dlsp_datapath.sv
hdl/dlsp_ctrl.sv
hdl/dense_layer_sigmoid_propagation_core.sv
dv/dense_layer_sigmoid_propagation_core_test.sv
